// ===== src/ecf_pkg.sv =====
package ecf_pkg;

	// Grid geometry: (1 << GRID_LOG2) cells along each tile edge.
	localparam int GRID_LOG2  = 6;
	localparam int CELL_AW    = 2 * GRID_LOG2;
	localparam int CELL_COUNT = 1 << CELL_AW;
	localparam int POS_W      = 16;

	// Field widths.
	localparam int HEIGHT_W  = 24;
	localparam int THR_W     = 23;
	localparam int CNT_W     = 8;
	localparam int TIME_W    = 32;
	localparam int VAR_W     = 32;
	localparam int IDX_W     = 12;
	localparam int OUTC_W    = 3;
	localparam int CFG_IDX_W = 3;

	// Disagreement window in milliseconds and the gray-zone blend divisor.
	localparam logic [TIME_W-1:0] WINDOW_MS = 32'd1000;
	localparam logic [CNT_W-1:0]  GRAY_DIV  = 8'd10;

	// Shared divider: numerator bits, divisor bits, quotient bits per cycle.
	localparam int DIV_NW    = 48;
	localparam int DIV_DW    = 8;
	localparam int DIV_BPC   = 4;
	localparam int DIV_STEPS = DIV_NW / DIV_BPC;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// Division by ten of the variance numerator, split as n = hi * 2^24 + lo:
	// n / 10 = hi * floor(2^24 / 10) + (6 * hi + lo) / 10, where the last part
	// is a reciprocal multiply that is exact for values below 2^26.
	localparam int          VN_LO_W   = 24;
	localparam logic [20:0] TEN_HI_Q  = 21'd1677721;
	localparam logic [25:0] TEN_RECIP = 26'd53687092;
	localparam int          TEN_SHIFT = 29;

	// Outcome codes.
	localparam logic [OUTC_W-1:0] OUT_SEEDED   = 3'd0;
	localparam logic [OUTC_W-1:0] OUT_ACCEPTED = 3'd1;
	localparam logic [OUTC_W-1:0] OUT_GRAY     = 3'd2;
	localparam logic [OUTC_W-1:0] OUT_DISAGREE = 3'd3;
	localparam logic [OUTC_W-1:0] OUT_REPLACED = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_THR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPLOAD_THR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CAP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_CONF    = 3'd5;

	// One cell of the height grid as held in memory.
	typedef struct packed {
		logic                       valid;
		logic signed [HEIGHT_W-1:0] mean;
		logic signed [HEIGHT_W-1:0] reported;
		logic [VAR_W-1:0]           variance;
		logic [CNT_W-1:0]           count;
		logic [CNT_W-1:0]           disagree;
		logic [TIME_W-1:0]          last;
	} cell_t;

endpackage

// ===== src/elevation_cell_fusion_unit.sv =====
// Height-grid fusion for one tile. After reset the block sweeps all 4096 cells of its
// memory to invalid, one cell per cycle; busy is high during the sweep and start is
// not taken. A point is taken when start is high and busy is low. Points that seed a
// cell or land in the disagreement band go from the read and evaluation states
// straight to the final write; points that update the mean (accept or gray zone)
// first wait in the divider that forms the rounded mean step; the variance blend is
// a reciprocal multiply that completes while the divider runs. One point is worked
// on at a time, and each yields exactly one result, shown for a single cycle with
// done high; the receiver must take it then. Configuration is written through
// cfg_valid and cfg_ready, which is always high; the user must write it only while
// busy is low, and the block itself does not enforce this.
module elevation_cell_fusion_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [ecf_pkg::POS_W-1:0]             x_pos,
	input  logic [ecf_pkg::POS_W-1:0]             z_pos,
	input  logic signed [ecf_pkg::HEIGHT_W-1:0]   height_in,
	input  logic [ecf_pkg::TIME_W-1:0]            timestamp_ms,
	output logic                                  done,
	output logic [ecf_pkg::IDX_W-1:0]             cell_index,
	output logic signed [ecf_pkg::HEIGHT_W-1:0]   cell_mean,
	output logic [ecf_pkg::VAR_W-1:0]             cell_variance,
	output logic [ecf_pkg::CNT_W-1:0]             sample_count,
	output logic [ecf_pkg::OUTC_W-1:0]            outcome,
	output logic                                  dirty_raised,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ecf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ecf_pkg::THR_W-1:0]             cfg_data
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_START = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	localparam int HW = ecf_pkg::HEIGHT_W;
	localparam int CW = ecf_pkg::CNT_W;
	localparam int AW = ecf_pkg::CELL_AW;
	localparam int GL = ecf_pkg::GRID_LOG2;
	localparam int NW = ecf_pkg::DIV_NW;

	// Configuration registers.
	logic [ecf_pkg::THR_W-1:0] acc_thr_q, rep_thr_q, upl_thr_q;
	logic [CW-1:0]             confirm_q, cap_q, low_conf_q;

	// Control and item registers.
	logic [2:0]                state_q;
	logic [AW-1:0]             clr_q;
	logic [AW-1:0]             cell_q;
	logic signed [HW-1:0]      h_q;
	logic [ecf_pkg::TIME_W-1:0] now_q;
	ecf_pkg::cell_t            ent_q;
	ecf_pkg::cell_t            new_q;
	logic [HW-1:0]             dz_q;
	logic                      neg_q;
	logic                      chk_q;
	logic                      acc_q;
	logic                      dirty_q;
	logic [ecf_pkg::OUTC_W-1:0] outc_q;
	logic [2*HW-1:0]           sq_q;
	logic [CW-1:0]             den_q;
	logic                      tile_dirty_q;

	// Result registers.
	logic                          done_q;
	logic [ecf_pkg::IDX_W-1:0]     idx_q;
	logic signed [HW-1:0]          mean_q;
	logic [ecf_pkg::VAR_W-1:0]     var_q;
	logic [CW-1:0]                 cnt_q;
	logic [ecf_pkg::OUTC_W-1:0]    res_outc_q;
	logic                          res_dirty_q;

	// Memory and divider connections.
	logic                      accept;
	logic [AW-1:0]             in_cell;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	ecf_pkg::cell_t            ram_wdata;
	ecf_pkg::cell_t            rd_cell;
	logic                      div_start;
	logic [NW-1:0]             mnum, vnum, mquot;
	logic                      mdone;

	// Variance blend pipeline.
	logic [44:0]               vhi_s1;
	logic [26:0]               vlo_s1;
	logic [52:0]               vprod;
	logic [NW-1:0]             vq_s2;

	// Evaluation signals.
	logic signed [HW:0]        delta_c;
	logic [HW:0]               mag_c;
	logic                      in_acc, in_rep, in_window;
	logic [ecf_pkg::TIME_W-1:0] elapsed;
	logic [CW:0]               np9, np9c;
	logic [CW-1:0]             np8, den_c, dis_inc;
	logic signed [HW:0]        drift_c;
	logic [HW:0]               drift_mag;
	logic                      upl_hit;
	ecf_pkg::cell_t            fin_cell;
	logic                      fin_dirty;
	logic [AW+ecf_pkg::IDX_W-1:0] idx_wide;

	function automatic ecf_pkg::cell_t seed_cell(input logic signed [HW-1:0] h,
			input logic [ecf_pkg::TIME_W-1:0] last);
		ecf_pkg::cell_t c;
		c.valid    = 1'b1;
		c.mean     = h;
		c.reported = h;
		c.variance = '0;
		c.count    = CW'(1);
		c.disagree = '0;
		c.last     = last;
		return c;
	endfunction

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && (state_q == ST_IDLE);
	assign in_cell   = {z_pos[ecf_pkg::POS_W-1 -: GL], x_pos[ecf_pkg::POS_W-1 -: GL]};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_thr_q  <= 23'd1024;
			rep_thr_q  <= 23'd2867;
			upl_thr_q  <= 23'd246;
			confirm_q  <= 8'd3;
			cap_q      <= 8'd20;
			low_conf_q <= 8'd5;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ecf_pkg::CFG_ACCEPT_THR:  acc_thr_q  <= cfg_data;
				ecf_pkg::CFG_REPLACE_THR: rep_thr_q  <= cfg_data;
				ecf_pkg::CFG_UPLOAD_THR:  upl_thr_q  <= cfg_data;
				ecf_pkg::CFG_CONFIRM:     confirm_q  <= cfg_data[CW-1:0];
				ecf_pkg::CFG_COUNT_CAP:   cap_q      <= cfg_data[CW-1:0];
				ecf_pkg::CFG_LOW_CONF:    low_conf_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Cell memory: cleared after reset, then one read-modify-write per point.
	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_FIN);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : cell_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : fin_cell;

	ecf_ram #(
		.WIDTH($bits(ecf_pkg::cell_t)),
		.DEPTH(ecf_pkg::CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_cell),
		.rdata (rd_cell)
	);

	// Mean step through the divider; it serves both the accept and gray paths.
	assign div_start = (state_q == ST_START);
	assign mnum = NW'(dz_q) + NW'(den_q >> 1);
	assign vnum = NW'({ent_q.variance, 3'b000}) + NW'(ent_q.variance) + NW'(sq_q) + NW'(5);

	ecf_div u_mdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mnum),
		.den    (den_q),
		.done   (mdone),
		.quot   (mquot)
	);

	// Variance blend divided by ten; the numerator is stable from the evaluation
	// step on, so the quotient is ready long before the mean step.
	assign vprod = 53'(vlo_s1) * 53'(ecf_pkg::TEN_RECIP);

	always_ff @(posedge clk) begin
		vhi_s1 <= 45'(vnum[NW-1:ecf_pkg::VN_LO_W]) * 45'(ecf_pkg::TEN_HI_Q);
		vlo_s1 <= 27'({vnum[NW-1:ecf_pkg::VN_LO_W], 2'b00})
			+ 27'({vnum[NW-1:ecf_pkg::VN_LO_W], 1'b0})
			+ 27'(vnum[ecf_pkg::VN_LO_W-1:0]);
		vq_s2  <= NW'(vhi_s1) + NW'(vprod[52:ecf_pkg::TEN_SHIFT]);
	end

	// Difference between the new height and the stored mean.
	assign delta_c = {h_q[HW-1], h_q} - {rd_cell.mean[HW-1], rd_cell.mean};
	assign mag_c   = delta_c[HW] ? -delta_c : delta_c;

	// Band tests, window test and the capped count for the accept path.
	assign in_acc    = dz_q <= {1'b0, acc_thr_q};
	assign in_rep    = dz_q >= {1'b0, rep_thr_q};
	assign elapsed   = now_q - ent_q.last;
	assign in_window = elapsed <= ecf_pkg::WINDOW_MS;
	assign np9       = {1'b0, ent_q.count} + 1'b1;
	assign np9c      = (np9 > {1'b0, cap_q}) ? {1'b0, cap_q} : np9;
	assign np8       = np9c[CW-1:0];
	assign den_c     = (np8 == '0) ? CW'(1) : np8;
	assign dis_inc   = !in_window ? CW'(1) : ((ent_q.disagree == '1) ? ent_q.disagree
		: ent_q.disagree + 1'b1);

	// Drift since the last report decides whether the cell goes dirty.
	assign drift_c   = {new_q.mean[HW-1], new_q.mean} - {new_q.reported[HW-1], new_q.reported};
	assign drift_mag = drift_c[HW] ? -drift_c : drift_c;
	assign upl_hit   = chk_q && (drift_mag > (HW+1)'(upl_thr_q));

	always_comb begin
		fin_cell = new_q;
		if (upl_hit) begin
			fin_cell.reported = new_q.mean;
		end
	end
	assign fin_dirty = dirty_q || upl_hit;
	assign idx_wide  = {{ecf_pkg::IDX_W{1'b0}}, cell_q};

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			done_q       <= 1'b0;
			tile_dirty_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ:  state_q <= ST_EVAL;
				ST_EVAL: begin
					if (!ent_q.valid || (!in_acc && in_rep)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_START;
					end
				end
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (mdone) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q       <= 1'b1;
					tile_dirty_q <= tile_dirty_q || fin_dirty;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cell_q <= in_cell;
				h_q    <= height_in;
				now_q  <= timestamp_ms;
			end
			ST_READ: begin
				ent_q <= rd_cell;
				dz_q  <= mag_c[HW-1:0];
				neg_q <= delta_c[HW];
			end
			ST_EVAL: begin
				sq_q <= dz_q * dz_q;
				if (!ent_q.valid) begin
					new_q   <= seed_cell(h_q, ent_q.last);
					outc_q  <= ecf_pkg::OUT_SEEDED;
					dirty_q <= 1'b1;
					chk_q   <= 1'b0;
				end else if (in_acc) begin
					new_q          <= ent_q;
					new_q.count    <= np8;
					new_q.disagree <= '0;
					den_q          <= den_c;
					acc_q          <= 1'b1;
					outc_q         <= ecf_pkg::OUT_ACCEPTED;
					dirty_q        <= 1'b0;
					chk_q          <= 1'b1;
				end else if (in_rep) begin
					chk_q <= 1'b0;
					if ((ent_q.count < low_conf_q) || (dis_inc >= confirm_q)) begin
						new_q   <= seed_cell(h_q, now_q);
						outc_q  <= ecf_pkg::OUT_REPLACED;
						dirty_q <= 1'b1;
					end else begin
						new_q          <= ent_q;
						new_q.disagree <= dis_inc;
						new_q.last     <= now_q;
						outc_q         <= ecf_pkg::OUT_DISAGREE;
						dirty_q        <= 1'b0;
					end
				end else begin
					new_q          <= ent_q;
					new_q.disagree <= in_window ? ent_q.disagree : '0;
					den_q          <= ecf_pkg::GRAY_DIV;
					acc_q          <= 1'b0;
					outc_q         <= ecf_pkg::OUT_GRAY;
					dirty_q        <= 1'b0;
					chk_q          <= 1'b1;
				end
			end
			ST_DIV: begin
				if (mdone) begin
					new_q.mean <= neg_q ? ent_q.mean - mquot[HW-1:0]
						: ent_q.mean + mquot[HW-1:0];
					if (acc_q) begin
						new_q.variance <= (vq_s2[NW-1:ecf_pkg::VAR_W] != '0) ? '1
							: vq_s2[ecf_pkg::VAR_W-1:0];
					end
				end
			end
			ST_FIN: begin
				idx_q       <= idx_wide[ecf_pkg::IDX_W-1:0];
				mean_q      <= fin_cell.mean;
				var_q       <= fin_cell.variance;
				cnt_q       <= fin_cell.count;
				res_outc_q  <= outc_q;
				res_dirty_q <= fin_dirty;
			end
			default: ;
		endcase
	end

	assign done          = done_q;
	assign cell_index    = idx_q;
	assign cell_mean     = mean_q;
	assign cell_variance = var_q;
	assign sample_count  = cnt_q;
	assign outcome       = res_outc_q;
	assign dirty_raised  = res_dirty_q;

`ifndef SYNTH
	// A taken point keeps the block busy and cannot produce a result at once.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && !done))
		else $error("result strobe right after a point was taken");

	// A dirty result leaves the tile marked dirty.
	a_tile_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dirty_raised) |-> tile_dirty_q)
		else $error("dirty result did not mark the tile");

	// A seeded cell holds one sample, zero variance, and is dirty.
	a_seed_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (outcome == ecf_pkg::OUT_SEEDED)) |->
		(sample_count == CW'(1) && cell_variance == '0 && dirty_raised))
		else $error("seeded cell has wrong contents");

	// A counted disagreement never reports the cell dirty.
	a_disagree_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (outcome == ecf_pkg::OUT_DISAGREE)) |-> !dirty_raised)
		else $error("disagreement raised dirty");
`endif

endmodule

// ===== src/ecf_ram.sv =====
module ecf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ecf_div.sv =====
module ecf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ecf_pkg::DIV_NW-1:0]    num,
	input  logic [ecf_pkg::DIV_DW-1:0]    den,
	output logic                          done,
	output logic [ecf_pkg::DIV_NW-1:0]    quot
);

	logic                          run_q;
	logic                          done_q;
	logic [ecf_pkg::DIV_CW-1:0]    step_q;
	logic [ecf_pkg::DIV_NW-1:0]    n_q;
	logic [ecf_pkg::DIV_DW-1:0]    r_q;
	logic [ecf_pkg::DIV_DW-1:0]    d_q;
	logic [ecf_pkg::DIV_NW-1:0]    n_c;
	logic [ecf_pkg::DIV_DW-1:0]    r_c;
	logic [ecf_pkg::DIV_DW:0]      t_c;

	// Restoring division, a few quotient bits per cycle. The numerator register
	// shifts out at the top and collects quotient bits at the bottom.
	always_comb begin
		n_c = n_q;
		r_c = r_q;
		t_c = '0;
		for (int k = 0; k < ecf_pkg::DIV_BPC; k++) begin
			t_c = {r_c, n_c[ecf_pkg::DIV_NW-1]};
			n_c = {n_c[ecf_pkg::DIV_NW-2:0], 1'b0};
			if (t_c >= {1'b0, d_q}) begin
				t_c = t_c - {1'b0, d_q};
				n_c[0] = 1'b1;
			end
			r_c = t_c[ecf_pkg::DIV_DW-1:0];
		end
	end

	// Step control and operand registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == ecf_pkg::DIV_CW'(ecf_pkg::DIV_STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			n_q <= n_c;
			r_q <= r_c;
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

// ===== sim/elevation_cell_fusion_unit_tb.sv =====
module elevation_cell_fusion_unit_tb;
	import ecf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int GRID_N      = 1 << GRID_LOG2;

	typedef struct packed {
		logic [IDX_W-1:0]           index;
		logic signed [HEIGHT_W-1:0] mean;
		logic [VAR_W-1:0]           variance;
		logic [CNT_W-1:0]           count;
		logic [OUTC_W-1:0]          outcome;
		logic                       dirty;
	} cell_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [POS_W-1:0]           x_pos;
	logic [POS_W-1:0]           z_pos;
	logic signed [HEIGHT_W-1:0] height_in;
	logic [TIME_W-1:0]          timestamp_ms;
	logic                       done;
	logic [IDX_W-1:0]           cell_index;
	logic signed [HEIGHT_W-1:0] cell_mean;
	logic [VAR_W-1:0]           cell_variance;
	logic [CNT_W-1:0]           sample_count;
	logic [OUTC_W-1:0]          outcome;
	logic                       dirty_raised;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [THR_W-1:0]           cfg_data;

	// Shadow copy of the configuration and of the grid.
	logic [THR_W-1:0]           accept_thr, replace_thr, upload_thr;
	logic [CNT_W-1:0]           confirm_hits, count_cap, low_conf;
	logic signed [HEIGHT_W-1:0] grid_mean [CELL_COUNT];
	logic signed [HEIGHT_W-1:0] grid_reported [CELL_COUNT];
	logic [VAR_W-1:0]           grid_variance [CELL_COUNT];
	logic [CNT_W-1:0]           grid_count [CELL_COUNT];
	logic [CNT_W-1:0]           grid_disagree [CELL_COUNT];
	logic [TIME_W-1:0]          grid_last [CELL_COUNT];
	logic                       grid_valid [CELL_COUNT];

	cell_result_t pending_cells[$];
	int           mismatches = 0;
	int           cycles = 0;
	logic [TIME_W-1:0] scan_clock;

	elevation_cell_fusion_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_pos(x_pos), .z_pos(z_pos), .height_in(height_in), .timestamp_ms(timestamp_ms),
		.done(done), .cell_index(cell_index), .cell_mean(cell_mean),
		.cell_variance(cell_variance), .sample_count(sample_count), .outcome(outcome),
		.dirty_raised(dirty_raised), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Run-length guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic longint round_div(longint num, longint div);
		longint q;
		q = ((num < 0 ? -num : num) + div / 2) / div;
		return num < 0 ? -q : q;
	endfunction

	// Drift check shared by the accept and gray paths.
	function automatic logic mark_upload(int c);
		longint drift;
		drift = longint'(grid_mean[c]) - longint'(grid_reported[c]);
		if (drift < 0) drift = -drift;
		if (drift > longint'(upload_thr)) begin
			grid_reported[c] = grid_mean[c];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void seed_cell(int c, logic signed [HEIGHT_W-1:0] h);
		grid_mean[c]     = h;
		grid_reported[c] = h;
		grid_variance[c] = '0;
		grid_count[c]    = 8'd1;
		grid_disagree[c] = '0;
		grid_valid[c]    = 1'b1;
	endfunction

	// Fuses one point into the shadow grid and returns the expected result.
	function automatic cell_result_t fuse_point(logic [POS_W-1:0] x, logic [POS_W-1:0] z,
			logic signed [HEIGHT_W-1:0] h, logic [TIME_W-1:0] now);
		cell_result_t r;
		int           c;
		longint       delta, dz, np, v;
		logic [TIME_W-1:0] elapsed;
		c = ((int'(z >> (POS_W - GRID_LOG2)) << GRID_LOG2) |
			int'(x >> (POS_W - GRID_LOG2))) & (CELL_COUNT - 1);
		r.dirty = 1'b0;
		if (!grid_valid[c]) begin
			seed_cell(c, h);
			r.outcome = OUT_SEEDED;
			r.dirty   = 1'b1;
		end else begin
			delta   = longint'(h) - longint'(grid_mean[c]);
			dz      = delta < 0 ? -delta : delta;
			elapsed = now - grid_last[c];
			if (dz <= longint'(accept_thr)) begin
				np = longint'(grid_count[c]) + 1;
				if (np > longint'(count_cap)) np = longint'(count_cap);
				grid_mean[c] = HEIGHT_W'(longint'(grid_mean[c])
					+ round_div(delta, np != 0 ? np : 1));
				v = (9 * longint'(grid_variance[c]) + delta * delta + 5) / 10;
				grid_variance[c] = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
				grid_count[c]    = np[7:0];
				grid_disagree[c] = '0;
				r.dirty   = mark_upload(c);
				r.outcome = OUT_ACCEPTED;
			end else if (dz >= longint'(replace_thr)) begin
				if (elapsed <= WINDOW_MS) begin
					if (grid_disagree[c] != 8'd255) grid_disagree[c]++;
				end else begin
					grid_disagree[c] = 8'd1;
				end
				grid_last[c] = now;
				if (grid_count[c] < low_conf || grid_disagree[c] >= confirm_hits) begin
					seed_cell(c, h);
					r.outcome = OUT_REPLACED;
					r.dirty   = 1'b1;
				end else begin
					r.outcome = OUT_DISAGREE;
				end
			end else begin
				grid_mean[c] = HEIGHT_W'(longint'(grid_mean[c]) + round_div(delta, 10));
				r.dirty = mark_upload(c);
				if (elapsed > WINDOW_MS) grid_disagree[c] = '0;
				r.outcome = OUT_GRAY;
			end
		end
		r.index    = c[IDX_W-1:0];
		r.mean     = grid_mean[c];
		r.variance = grid_variance[c];
		r.count    = grid_count[c];
		return r;
	endfunction

	// Appends one expected result to the queue of outstanding requests.
	function automatic void queue_expected(cell_result_t r);
		pending_cells.insert(pending_cells.size(), r);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// Result monitor: each strobed result is matched against the oldest expectation.
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && done) begin
			if (pending_cells.size() == 0) begin
				report_mismatch("unexpected result, cell", cell_index, -1);
			end else begin
				want = pending_cells.pop_front();
				if (cell_index != want.index) report_mismatch("cell_index", cell_index, want.index);
				if (cell_mean != want.mean) report_mismatch("cell_mean", cell_mean, want.mean);
				if (cell_variance != want.variance)
					report_mismatch("cell_variance", cell_variance, want.variance);
				if (sample_count != want.count)
					report_mismatch("sample_count", sample_count, want.count);
				if (outcome != want.outcome) report_mismatch("outcome", outcome, want.outcome);
				if (dirty_raised != want.dirty)
					report_mismatch("dirty_raised", dirty_raised, want.dirty);
			end
		end
	end

	// Sends one point; start stays high until the block takes the request.
	task automatic send_point(logic [POS_W-1:0] x, logic [POS_W-1:0] z,
			logic signed [HEIGHT_W-1:0] h, logic [TIME_W-1:0] now);
		start        <= 1'b1;
		x_pos        <= x;
		z_pos        <= z;
		height_in    <= h;
		timestamp_ms <= now;
		do @(posedge clk); while (busy);
		queue_expected(fuse_point(x, z, h, now));
	endtask

	// Random gap between bursts; the caller is always at a clock edge here.
	task automatic sender_pause();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_cells.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ACCEPT_THR:  accept_thr   = data;
			CFG_REPLACE_THR: replace_thr  = data;
			CFG_UPLOAD_THR:  upload_thr   = data;
			CFG_CONFIRM:     confirm_hits = data[CNT_W-1:0];
			CFG_COUNT_CAP:   count_cap    = data[CNT_W-1:0];
			CFG_LOW_CONF:    low_conf     = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(int acc, int rep, int upl, int conf, int cap, int low);
		wait_idle();
		write_reg(CFG_ACCEPT_THR, THR_W'(acc));
		write_reg(CFG_REPLACE_THR, THR_W'(rep));
		write_reg(CFG_UPLOAD_THR, THR_W'(upl));
		write_reg(CFG_CONFIRM, THR_W'(conf));
		write_reg(CFG_COUNT_CAP, THR_W'(cap));
		write_reg(CFG_LOW_CONF, THR_W'(low));
	endtask

	function automatic logic [POS_W-1:0] pos_of(int cell_coord);
		return POS_W'((cell_coord << (POS_W - GRID_LOG2)) | $urandom_range(0, 1023));
	endfunction

	// Directed points: field extremes, every outcome and the named corner cases.
	task automatic test_directed();
		write_all(1024, 2867, 246, 3, 20, 2);
		send_point(16'h0000, 16'h0000, 24'sh7FFFFF, 32'd0);
		send_point(16'hFFFF, 16'hFFFF, -24'sh800000, 32'hFFFF_FFFF);
		send_point(16'h0000, 16'h0000, HEIGHT_W'(24'sh7FFFFF - 1000), 32'd10);
		send_point(16'h0000, 16'h0000, HEIGHT_W'(24'sh7FFFFF - 2000), 32'd20);
		send_point(16'h0000, 16'h0000, HEIGHT_W'(24'sh7FFFFF - 400), 32'd30);
		send_point(16'h03FF, 16'h0000, 24'sh1000, 32'd40);
		send_point(16'h03FF, 16'h0000, HEIGHT_W'(24'sh1000 + 100), 32'd50);
		send_point(16'h03FF, 16'h0000, HEIGHT_W'(24'sh1000 + 5000), 32'd100);
		send_point(16'h03FF, 16'h0000, HEIGHT_W'(24'sh1000 + 5000), 32'd1100);
		send_point(16'h03FF, 16'h0000, HEIGHT_W'(24'sh1000 + 5000), 32'd2101);
		send_point(16'h03FF, 16'h0000, HEIGHT_W'(24'sh1000 - 5000), 32'd50);
		send_point(16'h03FF, 16'h0000, HEIGHT_W'(24'sh1000 - 5000), 32'd60);
		send_point(16'h03FF, 16'h0000, HEIGHT_W'(24'sh1000 - 5000), 32'd70);
		send_point(16'hAAAA, 16'h5555, 24'sh0, 32'hAAAA_5555);
		send_point(16'h5555, 16'hAAAA, 24'sh0, 32'h5555_AAAA);
		send_point(16'hAAAA, 16'h5555, -24'sh800000, 32'hAAAA_5556);
		// Empty gray zone, zero count cap and zero confirm count.
		write_all(3000, 2000, 0, 0, 0, 0);
		send_point(16'h0000, 16'h0400, 24'sh10, 32'd5);
		send_point(16'h0000, 16'h0400, HEIGHT_W'(24'sh10 + 2500), 32'd6);
		send_point(16'h0000, 16'h0400, HEIGHT_W'(24'sh10 + 2800), 32'd7);
		send_point(16'h0000, 16'h0400, HEIGHT_W'(24'sh10 + 9000), 32'd8);
		send_point(16'h0000, 16'h0400, HEIGHT_W'(24'sh10 + 9001), 32'd9);
	endtask

	// Random points aimed at a handful of cells, with heights picked per band.
	task automatic test_random(int points, int n_cells);
		int cells_x [16];
		int cells_z [16];
		int k, c, band, pick;
		longint dh, h;
		for (k = 0; k < n_cells; k++) begin
			cells_x[k] = $urandom_range(0, GRID_N - 1);
			cells_z[k] = $urandom_range(0, GRID_N - 1);
		end
		for (k = 0; k < points; k++) begin
			pick = $urandom_range(0, n_cells - 1);
			c = (cells_z[pick] << GRID_LOG2) | cells_x[pick];
			band = $urandom_range(0, 9);
			case (band)
				0, 1, 2, 3: dh = $signed($urandom_range(0, 2 * accept_thr)) - longint'(accept_thr);
				4, 5: dh = longint'(accept_thr) + $urandom_range(1, 3000);
				6, 7: dh = longint'(replace_thr) + $urandom_range(0, 200000);
				8: dh = $signed($urandom_range(0, 16777215)) - 8388608;
				default: dh = 0;
			endcase
			if ($urandom_range(0, 1)) dh = -dh;
			h = longint'(grid_mean[c]) + dh;
			if (band == 9) h = $signed($urandom_range(0, 16777215)) - 8388608;
			// Timestamps mostly creep forward; sometimes jump or go back.
			case ($urandom_range(0, 9))
				0: scan_clock = $urandom();
				1: scan_clock = scan_clock - $urandom_range(1, 2000);
				2: scan_clock = scan_clock + $urandom_range(900, 1100);
				default: scan_clock = scan_clock + $urandom_range(0, 300);
			endcase
			if ($urandom_range(0, 15) == 0)
				send_point(POS_W'($urandom()), POS_W'($urandom()), h[HEIGHT_W-1:0], scan_clock);
			else
				send_point(pos_of(cells_x[pick]), pos_of(cells_z[pick]), h[HEIGHT_W-1:0],
					scan_clock);
			sender_pause();
		end
	endtask

	task automatic test_config_sweep();
		write_all(1024, 2867, 246, 3, 20, 5);
		test_random(500, 8);
		write_all(0, 0, 0, 255, 255, 255);
		test_random(200, 4);
		write_all(8388607, 8388607, 8388607, 1, 1, 0);
		test_random(200, 4);
		write_all($urandom_range(0, 8388607), $urandom_range(0, 8388607),
			$urandom_range(0, 8388607), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		test_random(200, 6);
		write_all(300, 600, 20, 2, 8, 3);
		test_random(500, 12);
		write_all(2000, 9000, 500, 4, 255, 1);
		test_random(400, 16);
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		x_pos        = '0;
		z_pos        = '0;
		height_in    = '0;
		timestamp_ms = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_ACCEPT_THR;
		cfg_data     = '0;
		scan_clock   = $urandom();
		accept_thr   = 1024;
		replace_thr  = 2867;
		upload_thr   = 246;
		confirm_hits = 3;
		count_cap    = 20;
		low_conf     = 5;
		for (int i = 0; i < CELL_COUNT; i++) begin
			grid_mean[i] = '0; grid_reported[i] = '0; grid_variance[i] = '0;
			grid_count[i] = '0; grid_disagree[i] = '0; grid_last[i] = '0;
			grid_valid[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// Let the clearing sweep finish before touching configuration.
		do @(posedge clk); while (busy);
		test_directed();
		test_config_sweep();
		wait_idle();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
